### hdl/tea_pkg.sv
// Shared types, constants and the TEA mixing function.
// Used by every module of the TEA ECB/CBC block.
package tea_pkg;

  localparam int unsigned TEA_ROUNDS = 32;
  localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [3:0][31:0] key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_MODE  = 3'd4,
    REG_IV    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } seq_ctrl_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] ka,
                                          input logic [31:0] kb, input logic [31:0] s);
    tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

### hdl/tea_core.sv
// Round datapath: holds the two half-block words and the running sum,
// and applies one full Feistel round pair per step. Depends on tea_pkg.
module tea_core import tea_pkg::*; #(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic        decrypt,
  input  key_t        key,
  input  logic [31:0] load_left,
  input  logic [31:0] load_right,
  output logic [31:0] res_left,
  output logic [31:0] res_right
);

  localparam logic [63:0] DEC_FULL  = 64'(TEA_DELTA) * 64'(ROUNDS);
  localparam logic [31:0] DEC_START = DEC_FULL[31:0];

  logic [31:0] a, b, sum, dir_unused_a;
  logic        dir;
  logic [31:0] a_next, b_next, sum_next;
  logic [31:0] enc_a, enc_b, dec_a, dec_b;

  assign dir_unused_a = '0;

  always_comb begin
    enc_a = a + tea_mix(b, key[0], key[1], sum);
    enc_b = b + tea_mix(enc_a, key[2], key[3], sum);
    dec_b = b - tea_mix(a, key[2], key[3], sum);
    dec_a = a - tea_mix(dec_b, key[0], key[1], sum);
    if (dir) begin
      a_next   = dec_a;
      b_next   = dec_b;
      sum_next = sum - TEA_DELTA;
    end else begin
      a_next   = enc_a;
      b_next   = enc_b;
      sum_next = sum + TEA_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a   <= load_left;
      b   <= load_right;
      dir <= decrypt;
      sum <= decrypt ? DEC_START : TEA_DELTA;
    end else if (step) begin
      a   <= a_next;
      b   <= b_next;
      sum <= sum_next;
    end
  end

  assign res_left  = a | dir_unused_a;
  assign res_right = b;

endmodule

### hdl/tea_seq.sv
// Sequencer: counts the round pairs of one block and hands the result
// to the output register when it is free. Depends on tea_pkg.
module tea_seq import tea_pkg::*; #(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      out_free,
  output logic      idle,
  output seq_ctrl_t ctrl
);

  localparam int unsigned CW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  seq_state_t    state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ctrl        = '0;
    idle        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle      = 1'b1;
        ctrl.load = start;
        cnt_next  = '0;
        if (start) state_next = ST_RUN;
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        ctrl.finish = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/tea_block_cipher_ecb_cbc.sv
// TEA block cipher on 64-bit words, ECB or CBC, encrypt or decrypt per word.
// A word is accepted when the block is idle; it is then loaded, run through
// ROUNDS round pairs of the shared round unit (32 at the default) and written
// to the output register once that is free; no new word is taken before that.
// The output register holds a result until taken and the next word may
// already be accepted meanwhile. Configuration port is always ready; write
// only while idle. Depends on tea_pkg, tea_core, tea_seq.
module tea_block_cipher_ecb_cbc import tea_pkg::*; #(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // block_left, block_right
  input  logic [1:0]           s_axis_tuser,   // kind, restart
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // out_left, out_right
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  key_t        key;
  logic        chain_mode;
  logic [63:0] init_vector;
  logic [63:0] chain_value;
  logic [63:0] blk_in;
  logic        kind_r;
  logic [63:0] out_data;
  logic        out_valid;

  logic        accept, idle, out_free;
  seq_ctrl_t   ctrl;
  logic [63:0] chain_sel, load_blk, res_blk, final_blk;
  logic [31:0] res_left, res_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      chain_mode  <= 1'b0;
      init_vector <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY0: key[0]      <= cfg_data[31:0];
        REG_KEY1: key[1]      <= cfg_data[31:0];
        REG_KEY2: key[2]      <= cfg_data[31:0];
        REG_KEY3: key[3]      <= cfg_data[31:0];
        REG_MODE: chain_mode  <= cfg_data[0];
        REG_IV:   init_vector <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // chain words: left in the upper half; tdata carries left in the low half
  assign chain_sel = s_axis_tuser[1] ? init_vector : chain_value;
  assign load_blk  = (chain_mode && !s_axis_tuser[0])
                   ? (s_axis_tdata ^ {chain_sel[31:0], chain_sel[63:32]})
                   : s_axis_tdata;

  tea_seq #(.ROUNDS(ROUNDS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  tea_core #(.ROUNDS(ROUNDS)) u_core (
    .clk        (clk),
    .load       (ctrl.load),
    .step       (ctrl.step),
    .decrypt    (s_axis_tuser[0]),
    .key        (key),
    .load_left  (load_blk[31:0]),
    .load_right (load_blk[63:32]),
    .res_left   (res_left),
    .res_right  (res_right)
  );

  assign res_blk   = {res_right, res_left};
  assign final_blk = (chain_mode && kind_r)
                   ? (res_blk ^ {chain_value[31:0], chain_value[63:32]})
                   : res_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
    end else if (accept && s_axis_tuser[1]) begin
      chain_value <= init_vector;
    end else if (ctrl.finish && chain_mode) begin
      chain_value <= kind_r ? {blk_in[31:0], blk_in[63:32]} : {res_left, res_right};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_in <= s_axis_tdata;
      kind_r <= s_axis_tuser[0];
    end
    if (ctrl.finish) out_data <= final_blk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("accepted word did not start the round sequence");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> out_free)
    else $error("result written over an untaken output word");

  a_rise_on_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ctrl.finish))
    else $error("output valid rose without a finished word");

  a_ecb_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (!chain_mode && !(accept && s_axis_tuser[1])) |=> $stable(chain_value))
    else $error("chain value changed in codebook mode");

endmodule
